FILE: hw/rtl/pet_pkg.sv
package pet_pkg;

   localparam int MAX_ATOMS      = 1024;
   localparam int SLOTS_PER_ATOM = 8;
   localparam int ATOM_W         = $clog2(MAX_ATOMS);
   localparam int SLOT_IDX_W     = (SLOTS_PER_ATOM > 1) ? $clog2(SLOTS_PER_ATOM) : 1;
   localparam int COUNT_W        = 15;
   localparam int COUNT_LIMIT    = 16384;
   localparam int PAIR_STEP      = 2;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_SEARCH = 1'b1;

   localparam logic STAT_OK   = 1'b0;
   localparam logic STAT_FULL = 1'b1;

   typedef struct packed {
      logic              valid;
      logic [ATOM_W-1:0] atom;
   } slot_type;

   typedef slot_type [SLOTS_PER_ATOM-1:0] row_type;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_IDX_W-1:0] idx;
   } pick_type;

   typedef struct packed {
      logic load_req;
      logic clear_wr;
      logic rd_a;
      logic rd_b;
      logic cap_a;
      logic check;
      logic wr_b;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic insert_ok;
      logic is_search;
   } stat_type;

   function automatic pick_type find_slot(row_type row, logic [ATOM_W-1:0] who);
      pick_type pick;
      pick = '0;
      for (int k = SLOTS_PER_ATOM - 1; k >= 0; k--) begin
         if (!row[k].valid || row[k].atom == who) begin
            pick.hit = 1'b1;
            pick.idx = SLOT_IDX_W'(k);
         end
      end
      return pick;
   endfunction

   function automatic logic row_holds(row_type row, logic [ATOM_W-1:0] who);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < SLOTS_PER_ATOM; k++) begin
         if (row[k].valid && row[k].atom == who) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   function automatic row_type set_slot(row_type row, logic [SLOT_IDX_W-1:0] idx,
                                        logic [ATOM_W-1:0] who);
      row_type upd;
      upd = row;
      for (int k = 0; k < SLOTS_PER_ATOM; k++) begin
         if (idx == SLOT_IDX_W'(k)) begin
            upd[k].valid = 1'b1;
            upd[k].atom  = who;
         end
      end
      return upd;
   endfunction

   function automatic logic atom_in_range(logic [ATOM_W-1:0] atom);
      return {1'b0, atom} < (ATOM_W + 1)'(MAX_ATOMS);
   endfunction

endpackage

FILE: hw/rtl/pet_ctrl.sv
module pet_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pet_pkg::stat_type stat,
   output pet_pkg::cmd_type  cmd,
   output logic              busy
);
   import pet_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_CLEAR   = 6'b000010,
      ST_READ_A  = 6'b000100,
      ST_READ_B  = 6'b001000,
      ST_CHECK   = 6'b010000,
      ST_WRITE_B = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_READ_A;
            end
         end
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ_A: begin
            cmd.rd_a = 1'b1;
            state_in = ST_READ_B;
         end
         ST_READ_B: begin
            cmd.rd_b  = 1'b1;
            cmd.cap_a = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (stat.is_search || !stat.insert_ok) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_WRITE_B;
            end
         end
         ST_WRITE_B: begin
            cmd.wr_b = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: hw/rtl/pet_datapath.sv
module pet_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  pet_pkg::cmd_type               cmd,
   input  logic                           req_action,
   input  logic [pet_pkg::ATOM_W-1:0]     req_atom_a,
   input  logic [pet_pkg::ATOM_W-1:0]     req_atom_b,
   output pet_pkg::stat_type              stat,
   output logic                           rsp_valid,
   output logic                           rsp_found,
   output logic                           rsp_status,
   output logic [pet_pkg::COUNT_W-1:0]    rsp_pair_count
);
   import pet_pkg::*;

   row_type mem [MAX_ATOMS];

   logic              action_ff;
   logic [ATOM_W-1:0] atom_a_ff;
   logic [ATOM_W-1:0] atom_b_ff;
   logic [ATOM_W-1:0] clr_addr_ff;
   row_type           rdata_ff;
   row_type           row_a_ff;
   row_type           row_b_new_ff;
   logic [COUNT_W-1:0] count_ff;
   logic              rsp_valid_ff;
   logic              rsp_found_ff;
   logic              rsp_status_ff;

   pick_type          pick_a;
   pick_type          pick_b;
   logic              in_range;
   logic              insert_ok;
   row_type           row_a_new;
   row_type           row_b_new;
   logic              mem_we;
   logic [ATOM_W-1:0] mem_waddr;
   row_type           mem_wdata;
   logic              mem_re;
   logic [ATOM_W-1:0] mem_raddr;
   logic [COUNT_W:0]  count_sum;
   logic [COUNT_W-1:0] count_in;

   always_comb begin
      pick_a    = find_slot(row_a_ff, atom_b_ff);
      pick_b    = find_slot(rdata_ff, atom_a_ff);
      in_range  = atom_in_range(atom_a_ff) && atom_in_range(atom_b_ff);
      insert_ok = in_range && pick_a.hit && pick_b.hit;
      row_a_new = set_slot(row_a_ff, pick_a.idx, atom_b_ff);
      row_b_new = set_slot(rdata_ff, pick_b.idx, atom_a_ff);
   end

   assign stat.clear_last = (clr_addr_ff == ATOM_W'(MAX_ATOMS - 1));
   assign stat.insert_ok  = insert_ok;
   assign stat.is_search  = (action_ff == ACT_SEARCH);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = atom_b_ff;
      mem_wdata = row_b_new_ff;
      priority if (cmd.clear_wr) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (cmd.check && action_ff == ACT_INSERT && insert_ok) begin
         mem_we    = 1'b1;
         mem_waddr = atom_a_ff;
         mem_wdata = row_a_new;
      end else if (cmd.wr_b) begin
         mem_we = 1'b1;
      end
   end

   assign mem_re    = cmd.rd_a || cmd.rd_b;
   assign mem_raddr = cmd.rd_a ? atom_a_ff : atom_b_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff <= req_action;
         atom_a_ff <= req_atom_a;
         atom_b_ff <= req_atom_b;
      end
      if (cmd.cap_a) begin
         row_a_ff <= rdata_ff;
      end
      if (cmd.check) begin
         row_b_new_ff <= row_b_new;
      end
   end

   always_comb begin
      count_sum = {1'b0, count_ff} + (COUNT_W + 1)'(PAIR_STEP);
      if (count_sum > (COUNT_W + 1)'(COUNT_LIMIT)) begin
         count_in = COUNT_W'(COUNT_LIMIT);
      end else begin
         count_in = count_sum[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_wr) begin
            clr_addr_ff <= clr_addr_ff + ATOM_W'(1);
         end
         if (cmd.wr_b) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= cmd.wr_b ||
                         (cmd.check && (action_ff == ACT_SEARCH || !insert_ok));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         rsp_found_ff  <= (action_ff == ACT_SEARCH) && atom_in_range(atom_a_ff) &&
                          row_holds(row_a_ff, atom_b_ff);
         rsp_status_ff <= (action_ff == ACT_INSERT && !insert_ok) ? STAT_FULL : STAT_OK;
      end else if (cmd.wr_b) begin
         rsp_found_ff  <= 1'b0;
         rsp_status_ff <= STAT_OK;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_pair_count = count_ff;

endmodule

FILE: hw/rtl/pair_exclusion_table.sv
// Response: rsp_valid rises once the request is done (after the check for a search or a
// refused insert, after the row b write for an accepted one); it lasts one cycle and cannot be stalled.
// Requests do not overlap: busy stays high until one is done. Steps of an accepted insert:
// load, read row a, read row b, write row a, write row b; a search or refused insert writes nothing.
// Reset: synchronous; a clearing pass then empties all 1024 rows, one row a
// cycle, holding busy high until it ends; the pair count returns to zero.
module pair_exclusion_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_action,
   input  logic [pet_pkg::ATOM_W-1:0]  req_atom_a,
   input  logic [pet_pkg::ATOM_W-1:0]  req_atom_b,
   output logic                        rsp_valid,
   output logic                        rsp_found,
   output logic                        rsp_status,
   output logic [pet_pkg::COUNT_W-1:0] rsp_pair_count
);
   import pet_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pet_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   pet_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_action     (req_action),
      .req_atom_a     (req_atom_a),
      .req_atom_b     (req_atom_b),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_pair_count (rsp_pair_count)
   );

endmodule
